FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the partitioner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define PSWP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PSWP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/pswp_pkg.sv
// Shared widths, register codes and the CORDIC arctangent table.
package pswp_pkg;

  localparam int ANGLE_W      = 16;
  localparam int OUT_IDX_W    = 6;
  localparam int DIFF_W       = 17;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_WIDTH = 2'd2;

  localparam logic [ANGLE_W-1:0] SWEEP_RESET = 16'd8192;

  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/polar_sweep_wedge_partitioner_unit.sv
// Top level of the polar sweep wedge partitioner: point store, sorter and wedge emitter.
//
// Points are offered on start with in_pos_x, in_pos_y and in_final_point, and a point
// is taken at a clock edge with start high and busy low. Each stored point takes the 24
// iterations of the shared CORDIC unit plus the store write.
// A point beyond MAX_NODES is dropped at once and marks the set as overflowed.
// The point carrying in_final_point starts the sort: an insertion sort over the point
// memory. Results then leave in angle order, one beat per out_valid pulse; a point
// that must skip empty wedges first waits for the serial remainder unit.
// out_valid lasts one cycle and cannot be held off by the receiver.
// Configuration writes on cfg_valid are always taken (cfg_ready is high) and must be
// made while busy is low. Reset clears the state, count, overflow flag and out_valid;
// the memory needs no clearing, as only entries written in the current set are read.
module polar_sweep_wedge_partitioner_unit #(
  parameter int MAX_NODES  = 64,
  parameter int ANGLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [pswp_pkg::ANGLE_W-1:0]  in_pos_x,
  input  logic signed [pswp_pkg::ANGLE_W-1:0]  in_pos_y,
  input  logic                                 in_final_point,
  output logic                                 out_valid,
  output logic [pswp_pkg::OUT_IDX_W-1:0]       out_point_index,
  output logic [pswp_pkg::ANGLE_W-1:0]         out_angle,
  output logic [pswp_pkg::OUT_IDX_W-1:0]       out_wedge_index,
  output logic                                 out_wedge_start,
  output logic                                 out_overflowed,
  output logic                                 out_last_result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pswp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pswp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pswp_pkg::*;
  `include "assert_macros.svh"

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int ENT_W = ANGLE_W + IDX_W;
  localparam int END_W = ANGLE_W + 2;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_NODES);

  typedef enum logic [3:0] {
    S_IDLE, S_CORDIC, S_SORT_KEY, S_SORT_KEYW, S_SORT_CMP, S_SORT_PUT,
    S_EM_RD, S_EM_EVAL, S_EM_MOD
  } state_t;

  state_t state_r;

  logic signed [ANGLE_W-1:0] depot_x_r, depot_y_r;
  logic [ANGLE_W-1:0]        sweep_r, sweep;
  logic [CNT_W-1:0]          count_r, k_r, j_r;
  logic                      overflow_r, final_r;
  logic [ENT_W-1:0]          mem [MAX_NODES];
  logic [ENT_W-1:0]          rd_data_r, key_r, ent_r, wr_data;
  logic [IDX_W-1:0]          rd_addr, wr_addr;
  logic                      wr_en, greater, accept, cordic_go, cordic_done;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic [ANGLE_W-1:0]        cordic_angle, mod_rem, rd_angle;
  logic                      mod_go, mod_done;
  logic [END_W-1:0]          end_r, a_ext, e2, sweep_ext;
  logic [OUT_IDX_W-1:0]      widx_r;
  logic                      last_now;

  logic                      out_valid_r, out_start_r, out_last_r, out_ovf_r;
  logic [OUT_IDX_W-1:0]      out_pidx_r, out_widx_r;
  logic [ANGLE_W-1:0]        out_angle_r;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cordic_go = accept && (count_r != FULL);
  assign cfg_ready = 1'b1;
  assign sweep     = (sweep_r == '0) ? ANGLE_W'(1) : sweep_r;
  assign sweep_ext = END_W'(sweep);
  assign dx = DIFF_W'(in_pos_x) - DIFF_W'(depot_x_r);
  assign dy = DIFF_W'(in_pos_y) - DIFF_W'(depot_y_r);
  assign rd_angle = rd_data_r[ENT_W-1 -: ANGLE_W];
  assign greater  = rd_angle > key_r[ENT_W-1 -: ANGLE_W];
  assign a_ext    = END_W'(rd_angle);
  assign e2       = end_r + sweep_ext;
  assign last_now = ((k_r + 1'b1) == count_r);
  assign mod_go   = (state_r == S_EM_EVAL) && (k_r != '0) && (a_ext > end_r) && (a_ext > e2);

  pswp_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .go(cordic_go), .dx(dx), .dy(dy),
    .done(cordic_done), .angle(cordic_angle)
  );

  pswp_mod u_mod (
    .clk(clk), .rst_n(rst_n), .go(mod_go), .num(ANGLE_W'(a_ext - e2)), .den(sweep),
    .done(mod_done), .rem(mod_rem)
  );

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = key_r;
    case (state_r)
      S_CORDIC: begin
        wr_en   = cordic_done;
        wr_addr = count_r[IDX_W-1:0];
        wr_data = {cordic_angle, count_r[IDX_W-1:0]};
      end
      S_SORT_KEY:  rd_addr = k_r[IDX_W-1:0];
      S_SORT_KEYW: rd_addr = IDX_W'(k_r - 1'b1);
      S_SORT_CMP: begin
        rd_addr = IDX_W'(j_r - CNT_W'(2));
        wr_en   = 1'b1;
        wr_addr = j_r[IDX_W-1:0];
        wr_data = greater ? rd_data_r : key_r;
      end
      S_SORT_PUT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      S_EM_RD: rd_addr = k_r[IDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depot_x_r <= '0;
      depot_y_r <= '0;
      sweep_r   <= SWEEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEPOT_X:     depot_x_r <= cfg_data;
        CFG_DEPOT_Y:     depot_y_r <= cfg_data;
        CFG_SWEEP_WIDTH: sweep_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            final_r <= in_final_point;
            if (count_r == FULL) begin
              overflow_r <= 1'b1;
              if (in_final_point) begin
                k_r     <= CNT_W'(1);
                state_r <= S_SORT_KEY;
              end
            end else begin
              state_r <= S_CORDIC;
            end
          end
        end
        S_CORDIC: begin
          if (cordic_done) begin
            count_r <= count_r + 1'b1;
            if (!final_r) begin
              state_r <= S_IDLE;
            end else if (count_r == '0) begin
              k_r     <= '0;
              state_r <= S_EM_RD;
            end else begin
              k_r     <= CNT_W'(1);
              state_r <= S_SORT_KEY;
            end
          end
        end
        S_SORT_KEY: state_r <= S_SORT_KEYW;
        S_SORT_KEYW: begin
          key_r   <= rd_data_r;
          j_r     <= k_r;
          state_r <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (greater) begin
            j_r <= j_r - 1'b1;
            if (j_r == CNT_W'(1)) begin
              state_r <= S_SORT_PUT;
            end
          end else if (last_now) begin
            k_r     <= '0;
            state_r <= S_EM_RD;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SORT_KEY;
          end
        end
        S_SORT_PUT: begin
          if (last_now) begin
            k_r     <= '0;
            state_r <= S_EM_RD;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SORT_KEY;
          end
        end
        S_EM_RD: state_r <= S_EM_EVAL;
        S_EM_EVAL: begin
          ent_r       <= rd_data_r;
          out_pidx_r  <= OUT_IDX_W'(rd_data_r[IDX_W-1:0]);
          out_angle_r <= rd_angle;
          out_ovf_r   <= overflow_r;
          out_last_r  <= last_now;
          if (k_r == '0) begin
            end_r       <= a_ext + sweep_ext;
            widx_r      <= '0;
            out_widx_r  <= '0;
            out_start_r <= 1'b1;
            out_valid_r <= 1'b1;
          end else if (a_ext > end_r) begin
            widx_r      <= widx_r + 1'b1;
            out_widx_r  <= widx_r + 1'b1;
            out_start_r <= 1'b1;
            if (a_ext > e2) begin
              state_r <= S_EM_MOD;
            end else begin
              end_r       <= e2;
              out_valid_r <= 1'b1;
            end
          end else begin
            out_widx_r  <= widx_r;
            out_start_r <= 1'b0;
            out_valid_r <= 1'b1;
          end
          if (!mod_go) begin
            if (last_now) begin
              count_r    <= '0;
              overflow_r <= 1'b0;
              state_r    <= S_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_EM_RD;
            end
          end
        end
        S_EM_MOD: begin
          if (mod_done) begin
            end_r <= END_W'(ent_r[ENT_W-1 -: ANGLE_W])
                     + ((mod_rem == '0) ? '0 : END_W'(sweep - mod_rem));
            out_valid_r <= 1'b1;
            if (last_now) begin
              count_r    <= '0;
              overflow_r <= 1'b0;
              state_r    <= S_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_EM_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_index = out_pidx_r;
  assign out_angle       = out_angle_r;
  assign out_wedge_index = out_widx_r;
  assign out_wedge_start = out_start_r;
  assign out_overflowed  = out_ovf_r;
  assign out_last_result = out_last_r;

  `PSWP_ASSERT(a_count_bound, count_r <= FULL, "point count beyond capacity")
  `PSWP_ASSERT(a_full_sets_ovf, accept && (count_r == FULL) |=> overflow_r, "drop not flagged")
  `PSWP_ASSERT(a_last_clears, out_valid_r && out_last_r |-> (count_r == '0) && !overflow_r, "set not cleared after last beat")
  `PSWP_ASSERT(a_cordic_state, cordic_done |-> (state_r == S_CORDIC), "angle finished outside load")
  `PSWP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && (count_r == '0), "reset left block busy")

endmodule

FILE: rtl/core/pswp_cordic.sv
// Iterative CORDIC vectoring unit giving the polar angle of an offset.
module pswp_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 go,
  input  logic signed [pswp_pkg::DIFF_W-1:0]   dx,
  input  logic signed [pswp_pkg::DIFF_W-1:0]   dy,
  output logic                                 done,
  output logic        [pswp_pkg::ANGLE_W-1:0]  angle
);
  import pswp_pkg::*;

  localparam logic [31:0] RND = 32'd1 << (31 - ANGLE_BITS);
  localparam int PAD = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
  localparam logic [ANGLE_W-1:0] MASK = ~((16'd1 << PAD) - 16'd1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic signed [CORDIC_W-1:0] x_r, y_r, sx, sy;
  logic        [31:0]         z_r, z_rnd;
  logic        [STEP_W-1:0]   i_r;
  logic                       run_r, done_r, zero_r;
  logic signed [DIFF_W:0]     dxn, dyn;

  always_comb begin
    dxn = dx[DIFF_W-1] ? -(DIFF_W+1)'(dx) : (DIFF_W+1)'(dx);
    dyn = dx[DIFF_W-1] ? -(DIFF_W+1)'(dy) : (DIFF_W+1)'(dy);
    sx = x_r >>> i_r;
    sy = y_r >>> i_r;
    z_rnd = z_r + RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        i_r    <= '0;
        zero_r <= (dx == '0) && (dy == '0);
        x_r    <= CORDIC_W'(dxn) <<< 12;
        y_r    <= CORDIC_W'(dyn) <<< 12;
        z_r    <= dx[DIFF_W-1] ? 32'h80000000 : 32'h0;
      end else if (run_r) begin
        if (!y_r[CORDIC_W-1]) begin
          x_r <= x_r + sy;
          y_r <= y_r - sx;
          z_r <= z_r + atan_turn(i_r);
        end else begin
          x_r <= x_r - sy;
          y_r <= y_r + sx;
          z_r <= z_r - atan_turn(i_r);
        end
        i_r <= i_r + 1'b1;
        if (i_r == LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign angle = zero_r ? '0 : (z_rnd[31:16] & MASK);

endmodule

FILE: rtl/core/pswp_mod.sv
// Bit-serial restoring remainder unit for the wedge end catch-up.
module pswp_mod (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic [pswp_pkg::ANGLE_W-1:0]        num,
  input  logic [pswp_pkg::ANGLE_W-1:0]        den,
  output logic                                done,
  output logic [pswp_pkg::ANGLE_W-1:0]        rem
);
  import pswp_pkg::*;

  logic [ANGLE_W:0]   rem_r, trial;
  logic [ANGLE_W-1:0] num_r, den_r;
  logic [STEP_W-1:0]  cnt_r;
  logic               run_r, done_r;

  assign trial = {rem_r[ANGLE_W-1:0], num_r[ANGLE_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= STEP_W'(ANGLE_W - 1);
        rem_r <= '0;
        num_r <= num;
        den_r <= den;
      end else if (run_r) begin
        rem_r <= (trial >= {1'b0, den_r}) ? trial - {1'b0, den_r} : trial;
        num_r <= num_r << 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r[ANGLE_W-1:0];

endmodule
